// File: hw/rtl/atrl_pkg.sv
// Shared constants and types for the adaptive transfer rate limiter.
`default_nettype none

package atrl_pkg;

    localparam int AMOUNT_WIDTH = 20;
    localparam int TIME_WIDTH   = 48;
    localparam int ACC_WIDTH    = AMOUNT_WIDTH + 1;
    localparam int RATE_WIDTH   = 32;
    localparam int USEC_WIDTH   = 20;
    localparam int PROD_WIDTH   = ACC_WIDTH + USEC_WIDTH;
    localparam int WAIT_WIDTH   = 41;
    localparam int THR_WIDTH    = 16;
    localparam int DIV_CNT_W    = $clog2(PROD_WIDTH + 1);

    localparam int IN_TDATA_W   = ((AMOUNT_WIDTH + TIME_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((WAIT_WIDTH + THR_WIDTH + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - WAIT_WIDTH - THR_WIDTH;

    localparam logic [USEC_WIDTH-1:0] USEC_PER_SEC   = USEC_WIDTH'(1000000);
    localparam logic [WAIT_WIDTH-1:0] LONG_STALL_US  = WAIT_WIDTH'(1000000);
    localparam logic [WAIT_WIDTH-1:0] SHORT_STALL_US = WAIT_WIDTH'(100);
    localparam logic [THR_WIDTH-1:0]  THRESH_RESET   = THR_WIDTH'(16384);
    localparam logic [THR_WIDTH-1:0]  THRESH_FLOOR   = THR_WIDTH'(2048);
    localparam logic [THR_WIDTH:0]    THRESH_CEIL    = (THR_WIDTH + 1)'(32768);

    typedef struct packed {
        logic [WAIT_WIDTH-1:0] wait_us;
        logic                  window_closed;
        logic [THR_WIDTH-1:0]  threshold_now;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/adaptive_transfer_rate_limiter.sv
// Adaptive transfer rate limiter: rate register, control core and output register.
//
// Usage:
//   Input stream (s_axis): one transfer event per transfer, tdata carries the
//   byte amount and the current microsecond time. Output stream (m_axis): one
//   result per event, tdata carries the stall in microseconds and the current
//   byte threshold, tuser flags that the window was evaluated and restarted.
//   The rate register is written through i_cfg_we/i_cfg_wdata; the user must
//   write it only while idle, the block does not enforce this. A rate of zero disables limiting.
//   Events that do not close a window pass through the evaluate state and the
//   pending result register to the output register. Events that close a window
//   also pass through the multiply state and the 41-step bit-serial divider
//   that computes the ideal time. One event is in work at a time; the next is
//   taken as soon as the result has moved to the output register.
//   Reset clears the rate, the window, the accumulator and sets the threshold
//   to 16384. When the receiver stalls, the result holds in the output
//   register and one further result may wait inside the core.
`default_nettype none

module adaptive_transfer_rate_limiter
    import atrl_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [RATE_WIDTH-1:0]  i_cfg_wdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // amount [19:0], now_us [67:20], zero fill above
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // wait_us [40:0], threshold_now [56:41], zero fill above
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // window_closed [0]
    output logic                        m_axis_tuser
);

    logic [RATE_WIDTH-1:0] r_rate;
    logic                  r_out_valid;
    t_result               r_out;

    logic                  res_valid;
    logic                  res_ready;
    t_result               res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= '0;
        end else if (i_cfg_we) begin
            r_rate <= i_cfg_wdata;
        end
    end

    atrl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_amount    (s_axis_tdata[AMOUNT_WIDTH-1:0]),
        .i_now       (s_axis_tdata[AMOUNT_WIDTH +: TIME_WIDTH]),
        .i_rate      (r_rate),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out.threshold_now, r_out.wait_us};
    assign m_axis_tuser  = r_out.window_closed;

endmodule

`default_nettype wire

// File: hw/rtl/atrl_div_serial.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module atrl_div_serial
    import atrl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [PROD_WIDTH-1:0] i_dividend,
    input  wire logic [RATE_WIDTH-1:0] i_divisor,
    output logic                       o_done,
    output logic [PROD_WIDTH-1:0]      o_quotient
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [PROD_WIDTH-1:0] r_q;
    logic [RATE_WIDTH-1:0] r_rem;
    logic [RATE_WIDTH-1:0] r_div;

    logic [RATE_WIDTH:0]   rem_sh;
    logic [RATE_WIDTH+1:0] diff;
    logic                  q_bit;

    always_comb begin
        rem_sh = {r_rem, r_q[PROD_WIDTH-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_div};
        q_bit  = ~diff[RATE_WIDTH+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(PROD_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend bits shift out at the top while quotient bits shift in below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[PROD_WIDTH-2:0], q_bit};
            r_rem <= q_bit ? diff[RATE_WIDTH-1:0] : rem_sh[RATE_WIDTH-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

`default_nettype wire

// File: hw/rtl/atrl_ctrl.sv
// Window state and sequencing for one transfer event at a time.
`default_nettype none

module atrl_ctrl
    import atrl_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [AMOUNT_WIDTH-1:0] i_amount,
    input  wire logic [TIME_WIDTH-1:0]   i_now,
    input  wire logic [RATE_WIDTH-1:0]   i_rate,
    output logic                         o_res_valid,
    input  wire logic                    i_res_ready,
    output t_result                      o_res
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EVAL = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_LDIV = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_UPD  = 7'b1000000
    } t_state;

    t_state                  r_state, n_state;
    logic                    r_out_pend;
    logic                    r_started;
    logic [TIME_WIDTH-1:0]   r_start_us;
    logic [ACC_WIDTH-1:0]    r_acc;
    logic [THR_WIDTH-1:0]    r_thr;
    logic [AMOUNT_WIDTH-1:0] r_amount;
    logic [TIME_WIDTH-1:0]   r_now;
    logic [TIME_WIDTH-1:0]   r_elapsed;
    logic [PROD_WIDTH-1:0]   r_prod;
    logic [WAIT_WIDTH-1:0]   r_stall;
    t_result                 r_res;

    logic                    div_done;
    logic [PROD_WIDTH-1:0]   div_quot;
    logic [ACC_WIDTH:0]      sum;
    logic [ACC_WIDTH-1:0]    acc_sat;
    logic [TIME_WIDTH-1:0]   elapsed;
    logic [TIME_WIDTH-1:0]   ideal;
    logic [THR_WIDTH-1:0]    thr_half;
    logic [THR_WIDTH:0]      thr_dbl;
    logic [THR_WIDTH-1:0]    thr_next;

    atrl_div_serial u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_LDIV),
        .i_dividend (r_prod),
        .i_divisor  (i_rate),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    always_comb begin
        sum      = {1'b0, r_acc} + (ACC_WIDTH + 1)'(r_amount);
        acc_sat  = sum[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : sum[ACC_WIDTH-1:0];
        elapsed  = r_now - r_start_us;
        ideal    = TIME_WIDTH'(div_quot);
        thr_half = r_thr >> 1;
        thr_dbl  = {r_thr, 1'b0};
        thr_next = r_thr;
        if (r_stall >= LONG_STALL_US) begin
            thr_next = (thr_half < THRESH_FLOOR) ? THRESH_FLOOR : thr_half;
        end else if (r_stall != '0 && r_stall < SHORT_STALL_US) begin
            thr_next = (thr_dbl > THRESH_CEIL) ? THRESH_CEIL[THR_WIDTH-1:0]
                                               : thr_dbl[THR_WIDTH-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && !r_out_pend) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_amount != '0 && i_rate != '0 && r_started &&
                    acc_sat >= ACC_WIDTH'(r_thr) && elapsed != '0) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MUL:  n_state = S_LDIV;
            S_LDIV: n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:  n_state = S_UPD;
            S_UPD:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_out_pend <= 1'b0;
            r_started  <= 1'b0;
            r_start_us <= '0;
            r_acc      <= '0;
            r_thr      <= THRESH_RESET;
        end else begin
            r_state <= n_state;
            if (r_out_pend && i_res_ready) begin
                r_out_pend <= 1'b0;
            end
            unique case (r_state)
                S_EVAL: begin
                    if (r_amount != '0 && i_rate != '0) begin
                        if (!r_started) begin
                            r_started  <= 1'b1;
                            r_start_us <= r_now;
                        end else begin
                            r_acc <= acc_sat;
                        end
                    end
                    if (n_state == S_IDLE) begin
                        r_out_pend <= 1'b1;
                    end
                end
                S_UPD: begin
                    r_thr      <= thr_next;
                    r_acc      <= '0;
                    r_start_us <= r_now + TIME_WIDTH'(r_stall);
                    r_out_pend <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid && !r_out_pend) begin
            r_amount <= i_amount;
            r_now    <= i_now;
        end
        if (r_state == S_EVAL) begin
            r_elapsed <= elapsed;
            r_res     <= '{wait_us: '0, window_closed: 1'b0, threshold_now: r_thr};
        end
        if (r_state == S_MUL) begin
            r_prod <= PROD_WIDTH'(r_acc) * PROD_WIDTH'(USEC_PER_SEC);
        end
        // Stall is the part of the ideal time not yet covered by elapsed time.
        if (r_state == S_FIN) begin
            r_stall <= (ideal > r_elapsed) ? WAIT_WIDTH'(ideal - r_elapsed) : '0;
        end
        if (r_state == S_UPD) begin
            r_res <= '{wait_us: r_stall, window_closed: 1'b1, threshold_now: thr_next};
        end
    end

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_pend;
    assign o_res_valid = r_out_pend;
    assign o_res       = r_res;

endmodule

`default_nettype wire

// File: hw/rtl/atrl_checker.sv
// Port-level checks for the adaptive transfer rate limiter, bound to the top level.
`default_nettype none

module atrl_checker
    import atrl_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    input  wire logic                   s_axis_tready,
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                   m_axis_tuser
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Only an evaluated window gives a stall.
    a_stall_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[WAIT_WIDTH-1:0] == '0)
        else $error("stall without window close");

    a_thr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            m_axis_tdata[WAIT_WIDTH +: THR_WIDTH] >= THRESH_FLOOR &&
            {1'b0, m_axis_tdata[WAIT_WIDTH +: THR_WIDTH]} <= THRESH_CEIL)
        else $error("threshold out of range");

    // One event in work at a time.
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second event taken while busy");

endmodule

bind adaptive_transfer_rate_limiter atrl_checker u_atrl_checker (.*);

`default_nettype wire
